FILE: design/xenc_pkg.sv
// Package for the x86-64 instruction byte encoder.
// Holds the request and result types, form codes and opcode constants.
// Depends on nothing; every design file imports it.
`default_nettype none

package xenc_pkg;

    localparam int MaxBytes = 10;
    localparam int CntW     = 4;

    typedef logic [CntW-1:0] byte_cnt_t;
    typedef logic [MaxBytes-1:0][7:0] code_bytes_t;

    typedef struct packed {
        logic [4:0]         mode;
        logic [3:0]         dst_reg;
        logic [3:0]         src_reg;
        logic [3:0]         base_reg;
        logic [3:0]         index_reg;
        logic [1:0]         scale;
        logic signed [31:0] displacement;
        logic [63:0]        immediate;
        logic [3:0]         condition;
        logic [7:0]         shift_count;
    } req_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } res_t;

    localparam logic [4:0] MODE_MOV_IMM64 = 5'd0;
    localparam logic [4:0] MODE_MOV_RR    = 5'd1;
    localparam logic [4:0] MODE_STORE     = 5'd2;
    localparam logic [4:0] MODE_LOAD      = 5'd3;
    localparam logic [4:0] MODE_LEA       = 5'd4;
    localparam logic [4:0] MODE_ADD_RR    = 5'd5;
    localparam logic [4:0] MODE_ADD_IMM   = 5'd6;
    localparam logic [4:0] MODE_SUB_RR    = 5'd7;
    localparam logic [4:0] MODE_SUB_IMM   = 5'd8;
    localparam logic [4:0] MODE_AND_IMM   = 5'd9;
    localparam logic [4:0] MODE_OR_IMM    = 5'd10;
    localparam logic [4:0] MODE_XOR_RR    = 5'd11;
    localparam logic [4:0] MODE_CMP_IMM   = 5'd12;
    localparam logic [4:0] MODE_CMP_RR    = 5'd13;
    localparam logic [4:0] MODE_IMUL_RR   = 5'd14;
    localparam logic [4:0] MODE_INC       = 5'd15;
    localparam logic [4:0] MODE_DEC       = 5'd16;
    localparam logic [4:0] MODE_NEG       = 5'd17;
    localparam logic [4:0] MODE_SHL       = 5'd18;
    localparam logic [4:0] MODE_SHR       = 5'd19;
    localparam logic [4:0] MODE_SAR       = 5'd20;
    localparam logic [4:0] MODE_JMP_REL   = 5'd21;
    localparam logic [4:0] MODE_JMP_REG   = 5'd22;
    localparam logic [4:0] MODE_JCC_REL   = 5'd23;
    localparam logic [4:0] MODE_CALL_REL  = 5'd24;
    localparam logic [4:0] MODE_CALL_REG  = 5'd25;
    localparam logic [4:0] MODE_RET       = 5'd26;
    localparam logic [4:0] MODE_PUSH      = 5'd27;
    localparam logic [4:0] MODE_POP       = 5'd28;

    localparam logic [7:0] OP_REX_W     = 8'h48;
    localparam logic [7:0] OP_REX_B     = 8'h41;
    localparam logic [7:0] OP_MOV_IMM   = 8'hB8;
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_LEA       = 8'h8D;
    localparam logic [7:0] OP_ADD       = 8'h01;
    localparam logic [7:0] OP_SUB       = 8'h29;
    localparam logic [7:0] OP_XOR       = 8'h31;
    localparam logic [7:0] OP_CMP       = 8'h39;
    localparam logic [7:0] OP_GRP1_IMM  = 8'h81;
    localparam logic [7:0] OP_ESCAPE    = 8'h0F;
    localparam logic [7:0] OP_IMUL      = 8'hAF;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] OP_GRP3      = 8'hF7;
    localparam logic [7:0] OP_SHIFT_IMM = 8'hC1;
    localparam logic [7:0] OP_JMP_REL   = 8'hE9;
    localparam logic [7:0] OP_JCC_BASE  = 8'h80;
    localparam logic [7:0] OP_CALL_REL  = 8'hE8;
    localparam logic [7:0] OP_RET       = 8'hC3;
    localparam logic [7:0] OP_PUSH      = 8'h50;
    localparam logic [7:0] OP_POP       = 8'h58;

    localparam logic [2:0] EXT_ADD  = 3'd0;
    localparam logic [2:0] EXT_OR   = 3'd1;
    localparam logic [2:0] EXT_CALL = 3'd2;
    localparam logic [2:0] EXT_NEG  = 3'd3;
    localparam logic [2:0] EXT_AND  = 3'd4;
    localparam logic [2:0] EXT_SUB  = 3'd5;
    localparam logic [2:0] EXT_CMP  = 3'd7;
    localparam logic [2:0] EXT_INC  = 3'd0;
    localparam logic [2:0] EXT_DEC  = 3'd1;
    localparam logic [2:0] EXT_JMP  = 3'd4;
    localparam logic [2:0] EXT_SHL  = 3'd4;
    localparam logic [2:0] EXT_SHR  = 3'd5;
    localparam logic [2:0] EXT_SAR  = 3'd7;

    localparam logic [1:0] MOD_NONE  = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG   = 2'd3;

    localparam logic [2:0] RM_SIB = 3'd4;
    localparam logic [2:0] RM_BP  = 3'd5;
    localparam logic [3:0] INDEX_NONE = 4'd4;

endpackage

`default_nettype wire

FILE: design/xenc_encode.sv
// Combinational encoder: turns one registered request into up to ten code bytes.
// Depends on xenc_pkg for the request type, form codes and opcodes.
`default_nettype none

module xenc_encode (
    input  var xenc_pkg::req_t        req,
    output var xenc_pkg::code_bytes_t code_bytes,
    output var xenc_pkg::byte_cnt_t   byte_cnt
);
    import xenc_pkg::*;

    function automatic logic [7:0] rex(input logic [3:0] r, input logic [3:0] m,
                                       input logic [3:0] x);
        return OP_REX_W | {5'd0, r[3], x[3], m[3]};
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] r,
                                         input logic [2:0] m);
        return {md, r, m};
    endfunction

    logic [31:0] imm32;
    logic        disp_zero;
    logic        disp_short;
    logic        base_bp;
    logic        sib_used;
    logic [1:0]  mem_mod;
    logic [3:0]  mem_reg;
    logic [7:0]  mem_op;
    logic [7:0]  mem_modrm;
    logic [7:0]  mem_sib;
    logic [CntW-1:0] disp_len;

    assign imm32      = req.immediate[31:0];
    assign disp_zero  = (req.displacement == 32'sd0);
    assign disp_short = (req.displacement[31:7] == '0) || (req.displacement[31:7] == '1);
    assign base_bp    = (req.base_reg[2:0] == RM_BP);
    assign sib_used   = !((req.index_reg == INDEX_NONE) && (req.scale == 2'd0)
                          && (req.base_reg[2:0] != RM_SIB));

    always_comb
    begin
        if (disp_zero && !base_bp)
        begin
            mem_mod  = MOD_NONE;
            disp_len = CntW'(0);
        end
        else if (disp_short)
        begin
            mem_mod  = MOD_DISP8;
            disp_len = CntW'(1);
        end
        else
        begin
            mem_mod  = MOD_DISP32;
            disp_len = CntW'(4);
        end
    end

    assign mem_reg   = (req.mode == MODE_STORE) ? req.src_reg : req.dst_reg;
    assign mem_op    = (req.mode == MODE_STORE) ? OP_MOV_STORE :
                       (req.mode == MODE_LOAD)  ? OP_MOV_LOAD  : OP_LEA;
    assign mem_modrm = modrm(mem_mod, mem_reg[2:0],
                             sib_used ? RM_SIB : req.base_reg[2:0]);
    assign mem_sib   = {req.scale, req.index_reg[2:0], req.base_reg[2:0]};

    always_comb
    begin
        code_bytes = '0;
        byte_cnt   = '0;
        unique case (req.mode)
            MODE_MOV_IMM64:
            begin
                code_bytes[0] = OP_REX_W | {7'd0, req.dst_reg[3]};
                code_bytes[1] = OP_MOV_IMM + {5'd0, req.dst_reg[2:0]};
                code_bytes[2] = req.immediate[7:0];
                code_bytes[3] = req.immediate[15:8];
                code_bytes[4] = req.immediate[23:16];
                code_bytes[5] = req.immediate[31:24];
                code_bytes[6] = req.immediate[39:32];
                code_bytes[7] = req.immediate[47:40];
                code_bytes[8] = req.immediate[55:48];
                code_bytes[9] = req.immediate[63:56];
                byte_cnt      = CntW'(10);
            end
            MODE_MOV_RR, MODE_ADD_RR, MODE_SUB_RR, MODE_XOR_RR, MODE_CMP_RR:
            begin
                code_bytes[0] = rex(req.src_reg, req.dst_reg, 4'd0);
                unique case (req.mode)
                    MODE_MOV_RR: code_bytes[1] = OP_MOV_STORE;
                    MODE_ADD_RR: code_bytes[1] = OP_ADD;
                    MODE_SUB_RR: code_bytes[1] = OP_SUB;
                    MODE_XOR_RR: code_bytes[1] = OP_XOR;
                    default:     code_bytes[1] = OP_CMP;
                endcase
                code_bytes[2] = modrm(MOD_REG, req.src_reg[2:0], req.dst_reg[2:0]);
                byte_cnt      = CntW'(3);
            end
            MODE_STORE, MODE_LOAD, MODE_LEA:
            begin
                code_bytes[0] = rex(mem_reg, req.base_reg, req.index_reg);
                code_bytes[1] = mem_op;
                code_bytes[2] = mem_modrm;
                if (sib_used)
                begin
                    code_bytes[3] = mem_sib;
                    code_bytes[4] = req.displacement[7:0];
                    code_bytes[5] = req.displacement[15:8];
                    code_bytes[6] = req.displacement[23:16];
                    code_bytes[7] = req.displacement[31:24];
                    byte_cnt      = CntW'(4) + disp_len;
                end
                else
                begin
                    code_bytes[3] = req.displacement[7:0];
                    code_bytes[4] = req.displacement[15:8];
                    code_bytes[5] = req.displacement[23:16];
                    code_bytes[6] = req.displacement[31:24];
                    byte_cnt      = CntW'(3) + disp_len;
                end
            end
            MODE_ADD_IMM, MODE_SUB_IMM, MODE_AND_IMM, MODE_OR_IMM, MODE_CMP_IMM:
            begin
                code_bytes[0] = rex(req.dst_reg, req.dst_reg, 4'd0);
                code_bytes[1] = OP_GRP1_IMM;
                unique case (req.mode)
                    MODE_ADD_IMM: code_bytes[2] = modrm(MOD_REG, EXT_ADD, req.dst_reg[2:0]);
                    MODE_SUB_IMM: code_bytes[2] = modrm(MOD_REG, EXT_SUB, req.dst_reg[2:0]);
                    MODE_AND_IMM: code_bytes[2] = modrm(MOD_REG, EXT_AND, req.dst_reg[2:0]);
                    MODE_OR_IMM:  code_bytes[2] = modrm(MOD_REG, EXT_OR, req.dst_reg[2:0]);
                    default:      code_bytes[2] = modrm(MOD_REG, EXT_CMP, req.dst_reg[2:0]);
                endcase
                code_bytes[3] = imm32[7:0];
                code_bytes[4] = imm32[15:8];
                code_bytes[5] = imm32[23:16];
                code_bytes[6] = imm32[31:24];
                byte_cnt      = CntW'(7);
            end
            MODE_IMUL_RR:
            begin
                code_bytes[0] = rex(req.dst_reg, req.src_reg, 4'd0);
                code_bytes[1] = OP_ESCAPE;
                code_bytes[2] = OP_IMUL;
                code_bytes[3] = modrm(MOD_REG, req.dst_reg[2:0], req.src_reg[2:0]);
                byte_cnt      = CntW'(4);
            end
            MODE_INC, MODE_DEC, MODE_NEG:
            begin
                code_bytes[0] = rex(req.dst_reg, req.dst_reg, 4'd0);
                unique case (req.mode)
                    MODE_INC:
                    begin
                        code_bytes[1] = OP_GRP5;
                        code_bytes[2] = modrm(MOD_REG, EXT_INC, req.dst_reg[2:0]);
                    end
                    MODE_DEC:
                    begin
                        code_bytes[1] = OP_GRP5;
                        code_bytes[2] = modrm(MOD_REG, EXT_DEC, req.dst_reg[2:0]);
                    end
                    default:
                    begin
                        code_bytes[1] = OP_GRP3;
                        code_bytes[2] = modrm(MOD_REG, EXT_NEG, req.dst_reg[2:0]);
                    end
                endcase
                byte_cnt = CntW'(3);
            end
            MODE_SHL, MODE_SHR, MODE_SAR:
            begin
                code_bytes[0] = rex(req.dst_reg, req.dst_reg, 4'd0);
                code_bytes[1] = OP_SHIFT_IMM;
                unique case (req.mode)
                    MODE_SHL: code_bytes[2] = modrm(MOD_REG, EXT_SHL, req.dst_reg[2:0]);
                    MODE_SHR: code_bytes[2] = modrm(MOD_REG, EXT_SHR, req.dst_reg[2:0]);
                    default:  code_bytes[2] = modrm(MOD_REG, EXT_SAR, req.dst_reg[2:0]);
                endcase
                code_bytes[3] = req.shift_count;
                byte_cnt      = CntW'(4);
            end
            MODE_JMP_REL, MODE_CALL_REL:
            begin
                code_bytes[0] = (req.mode == MODE_JMP_REL) ? OP_JMP_REL : OP_CALL_REL;
                code_bytes[1] = imm32[7:0];
                code_bytes[2] = imm32[15:8];
                code_bytes[3] = imm32[23:16];
                code_bytes[4] = imm32[31:24];
                byte_cnt      = CntW'(5);
            end
            MODE_JCC_REL:
            begin
                code_bytes[0] = OP_ESCAPE;
                code_bytes[1] = OP_JCC_BASE + {4'd0, req.condition};
                code_bytes[2] = imm32[7:0];
                code_bytes[3] = imm32[15:8];
                code_bytes[4] = imm32[23:16];
                code_bytes[5] = imm32[31:24];
                byte_cnt      = CntW'(6);
            end
            MODE_JMP_REG, MODE_CALL_REG:
            begin
                if (req.dst_reg[3])
                begin
                    code_bytes[0] = OP_REX_B;
                    code_bytes[1] = OP_GRP5;
                    code_bytes[2] = modrm(MOD_REG,
                                          (req.mode == MODE_JMP_REG) ? EXT_JMP : EXT_CALL,
                                          req.dst_reg[2:0]);
                    byte_cnt      = CntW'(3);
                end
                else
                begin
                    code_bytes[0] = OP_GRP5;
                    code_bytes[1] = modrm(MOD_REG,
                                          (req.mode == MODE_JMP_REG) ? EXT_JMP : EXT_CALL,
                                          req.dst_reg[2:0]);
                    byte_cnt      = CntW'(2);
                end
            end
            MODE_RET:
            begin
                code_bytes[0] = OP_RET;
                byte_cnt      = CntW'(1);
            end
            MODE_PUSH, MODE_POP:
            begin
                if (req.dst_reg[3])
                begin
                    code_bytes[0] = OP_REX_B;
                    code_bytes[1] = ((req.mode == MODE_PUSH) ? OP_PUSH : OP_POP)
                                    + {5'd0, req.dst_reg[2:0]};
                    byte_cnt      = CntW'(2);
                end
                else
                begin
                    code_bytes[0] = ((req.mode == MODE_PUSH) ? OP_PUSH : OP_POP)
                                    + {5'd0, req.dst_reg[2:0]};
                    byte_cnt      = CntW'(1);
                end
            end
            default:
            begin
                code_bytes = '0;
                byte_cnt   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/xenc_serial.sv
// Byte buffer and result register: holds one encoded instruction, sends a byte a cycle when not stalled.
// Depends on xenc_pkg for the code byte array and result types.
`default_nettype none

module xenc_serial (
    input  var logic                  clk,
    input  var logic                  rst_n,
    input  var logic                  load,
    input  var xenc_pkg::code_bytes_t code_bytes,
    input  var xenc_pkg::byte_cnt_t   byte_cnt,
    output var logic                  ready,
    output var logic                  res_valid,
    input  var logic                  res_stall,
    output var xenc_pkg::res_t        res
);
    import xenc_pkg::*;

    code_bytes_t bytes_reg;
    byte_cnt_t   cnt_reg;
    byte_cnt_t   idx_reg;
    logic        buf_valid_reg;
    logic        out_valid_reg;
    res_t        out_reg;

    logic out_adv;
    logic emit;
    logic at_last;

    assign out_adv = !out_valid_reg || !res_stall;
    assign emit    = buf_valid_reg && out_adv;
    assign at_last = (idx_reg == cnt_reg - CntW'(1));
    assign ready   = !buf_valid_reg || (emit && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                buf_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (emit)
            begin
                buf_valid_reg <= !at_last;
                idx_reg       <= idx_reg + CntW'(1);
            end
            if (out_adv)
            begin
                out_valid_reg <= buf_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= code_bytes;
            cnt_reg   <= byte_cnt;
        end
        if (emit)
        begin
            out_reg.code_byte <= bytes_reg[idx_reg];
            out_reg.last_byte <= at_last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

FILE: design/x86_64_instruction_byte_encoder_top.sv
// Top level of the x86-64 instruction byte encoder: request register, encoder and byte sender.
// Depends on xenc_pkg, xenc_encode and xenc_serial.
//
//   Channel   Direction  Handshake             Payload
//   request   in         req_valid, req_stall  req (xenc_pkg::req_t)
//   result    out        res_valid, res_stall  res (xenc_pkg::res_t), one code byte each
//
// An instruction of N bytes occupies the result port one byte per cycle unless res_stall
// holds it, so the sustained rate is set by the single byte-wide result register. A request
// passes the request register and the byte buffer before it reaches the result register.
// Requests for unused forms are taken and produce no bytes.
// Reset clears all valid flags; stalls on the result side back up to req_stall.
`default_nettype none

module x86_64_instruction_byte_encoder_top (
    input  var logic           clk,
    input  var logic           rst_n,
    input  var logic           req_valid,
    output var logic           req_stall,
    input  var xenc_pkg::req_t req,
    output var logic           res_valid,
    input  var logic           res_stall,
    output var xenc_pkg::res_t res
);
    import xenc_pkg::*;

    req_t        req_reg;
    logic        req_valid_reg;
    code_bytes_t enc_bytes;
    byte_cnt_t   enc_cnt;
    logic        ser_ready;
    logic        consume;
    logic        load;
    logic        accept;

    assign load      = req_valid_reg && (enc_cnt != '0) && ser_ready;
    assign consume   = req_valid_reg && ((enc_cnt == '0) || ser_ready);
    assign req_stall = req_valid_reg && !consume;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    xenc_encode u_encode (
        .req        (req_reg),
        .code_bytes (enc_bytes),
        .byte_cnt   (enc_cnt)
    );

    xenc_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .code_bytes (enc_bytes),
        .byte_cnt   (enc_cnt),
        .ready      (ser_ready),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the x86-64 instruction byte encoder.
// Depends on xenc_pkg and x86_64_instruction_byte_encoder_top; each request's bytes are
// predicted here and checked in order against the byte stream under random stalls.
`timescale 1ns / 100ps

module tb_top;
    import xenc_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 20;

    typedef logic [7:0] code_q_t[$];

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    res_t code_expected[$];
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   hold_ticket  = 0;
    int   hold_taken   = 0;
    bit   tx_calm      = 1'b0;
    bit   rx_calm      = 1'b0;

    x86_64_instruction_byte_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int draw_wait();
        if ($urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [7:0] rex_byte(logic [3:0] reg_num, logic [3:0] rm_num,
                                            logic [3:0] index_num);
        return OP_REX_W | {5'd0, reg_num[3], index_num[3], rm_num[3]};
    endfunction

    function automatic logic [7:0] modrm_byte(logic [1:0] mod_bits, logic [2:0] reg_bits,
                                              logic [2:0] rm_bits);
        return {mod_bits, reg_bits, rm_bits};
    endfunction

    function automatic code_q_t encode_instruction(req_t r);
        code_q_t    q;
        logic [3:0] mreg;
        logic [1:0] mod_bits;
        logic [7:0] op;
        logic [2:0] ext;
        case (r.mode)
            MODE_MOV_IMM64:
            begin
                q.push_back(OP_REX_W | {7'd0, r.dst_reg[3]});
                q.push_back(OP_MOV_IMM + {5'd0, r.dst_reg[2:0]});
                for (int k = 0; k < 8; k++)
                begin
                    q.push_back(r.immediate[8*k +: 8]);
                end
            end
            MODE_MOV_RR, MODE_ADD_RR, MODE_SUB_RR, MODE_XOR_RR, MODE_CMP_RR:
            begin
                case (r.mode)
                    MODE_MOV_RR: op = OP_MOV_STORE;
                    MODE_ADD_RR: op = OP_ADD;
                    MODE_SUB_RR: op = OP_SUB;
                    MODE_XOR_RR: op = OP_XOR;
                    default:     op = OP_CMP;
                endcase
                q.push_back(rex_byte(r.src_reg, r.dst_reg, 4'd0));
                q.push_back(op);
                q.push_back(modrm_byte(MOD_REG, r.src_reg[2:0], r.dst_reg[2:0]));
            end
            MODE_STORE, MODE_LOAD, MODE_LEA:
            begin
                mreg = (r.mode == MODE_STORE) ? r.src_reg : r.dst_reg;
                op = (r.mode == MODE_STORE) ? OP_MOV_STORE :
                     (r.mode == MODE_LOAD) ? OP_MOV_LOAD : OP_LEA;
                q.push_back(rex_byte(mreg, r.base_reg, r.index_reg));
                q.push_back(op);
                if ($signed(r.displacement) == 0 && r.base_reg[2:0] != RM_BP)
                begin
                    mod_bits = MOD_NONE;
                end
                else if ($signed(r.displacement) >= -128 && $signed(r.displacement) <= 127)
                begin
                    mod_bits = MOD_DISP8;
                end
                else
                begin
                    mod_bits = MOD_DISP32;
                end
                if (r.index_reg == INDEX_NONE && r.scale == 2'd0 && r.base_reg[2:0] != RM_SIB)
                begin
                    q.push_back(modrm_byte(mod_bits, mreg[2:0], r.base_reg[2:0]));
                end
                else
                begin
                    q.push_back(modrm_byte(mod_bits, mreg[2:0], RM_SIB));
                    q.push_back({r.scale, r.index_reg[2:0], r.base_reg[2:0]});
                end
                if (mod_bits == MOD_DISP8)
                begin
                    q.push_back(r.displacement[7:0]);
                end
                else if (mod_bits == MOD_DISP32)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        q.push_back(r.displacement[8*k +: 8]);
                    end
                end
            end
            MODE_ADD_IMM, MODE_SUB_IMM, MODE_AND_IMM, MODE_OR_IMM, MODE_CMP_IMM:
            begin
                case (r.mode)
                    MODE_ADD_IMM: ext = EXT_ADD;
                    MODE_SUB_IMM: ext = EXT_SUB;
                    MODE_AND_IMM: ext = EXT_AND;
                    MODE_OR_IMM:  ext = EXT_OR;
                    default:      ext = EXT_CMP;
                endcase
                q.push_back(rex_byte(r.dst_reg, r.dst_reg, 4'd0));
                q.push_back(OP_GRP1_IMM);
                q.push_back(modrm_byte(MOD_REG, ext, r.dst_reg[2:0]));
                for (int k = 0; k < 4; k++)
                begin
                    q.push_back(r.immediate[8*k +: 8]);
                end
            end
            MODE_IMUL_RR:
            begin
                q.push_back(rex_byte(r.dst_reg, r.src_reg, 4'd0));
                q.push_back(OP_ESCAPE);
                q.push_back(OP_IMUL);
                q.push_back(modrm_byte(MOD_REG, r.dst_reg[2:0], r.src_reg[2:0]));
            end
            MODE_INC, MODE_DEC, MODE_NEG:
            begin
                ext = (r.mode == MODE_INC) ? EXT_INC : (r.mode == MODE_DEC) ? EXT_DEC : EXT_NEG;
                q.push_back(rex_byte(r.dst_reg, r.dst_reg, 4'd0));
                q.push_back((r.mode == MODE_NEG) ? OP_GRP3 : OP_GRP5);
                q.push_back(modrm_byte(MOD_REG, ext, r.dst_reg[2:0]));
            end
            MODE_SHL, MODE_SHR, MODE_SAR:
            begin
                ext = (r.mode == MODE_SHL) ? EXT_SHL : (r.mode == MODE_SHR) ? EXT_SHR : EXT_SAR;
                q.push_back(rex_byte(r.dst_reg, r.dst_reg, 4'd0));
                q.push_back(OP_SHIFT_IMM);
                q.push_back(modrm_byte(MOD_REG, ext, r.dst_reg[2:0]));
                q.push_back(r.shift_count);
            end
            MODE_JMP_REL, MODE_CALL_REL, MODE_JCC_REL:
            begin
                if (r.mode == MODE_JCC_REL)
                begin
                    q.push_back(OP_ESCAPE);
                    q.push_back(OP_JCC_BASE + {4'd0, r.condition});
                end
                else
                begin
                    q.push_back((r.mode == MODE_JMP_REL) ? OP_JMP_REL : OP_CALL_REL);
                end
                for (int k = 0; k < 4; k++)
                begin
                    q.push_back(r.immediate[8*k +: 8]);
                end
            end
            MODE_JMP_REG, MODE_CALL_REG:
            begin
                if (r.dst_reg[3])
                begin
                    q.push_back(OP_REX_B);
                end
                q.push_back(OP_GRP5);
                q.push_back(modrm_byte(MOD_REG, (r.mode == MODE_JMP_REG) ? EXT_JMP : EXT_CALL,
                                       r.dst_reg[2:0]));
            end
            MODE_RET:
            begin
                q.push_back(OP_RET);
            end
            MODE_PUSH, MODE_POP:
            begin
                if (r.dst_reg[3])
                begin
                    q.push_back(OP_REX_B);
                end
                q.push_back(((r.mode == MODE_PUSH) ? OP_PUSH : OP_POP) + {5'd0, r.dst_reg[2:0]});
            end
            default:
            begin
            end
        endcase
        return q;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   boundary[4] = '{127, 128, -128, -129};
        if ($urandom_range(0, 15) == 0)
        begin
            r.mode = 5'($urandom_range(int'(MODE_POP) + 1, 2**5 - 1));
        end
        else
        begin
            r.mode = 5'($urandom_range(0, int'(MODE_POP)));
        end
        r.dst_reg     = 4'($urandom);
        r.src_reg     = 4'($urandom);
        r.base_reg    = 4'($urandom);
        r.index_reg   = 4'($urandom);
        r.scale       = 2'($urandom);
        r.immediate   = {$urandom, $urandom};
        r.condition   = 4'($urandom);
        r.shift_count = 8'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            r.index_reg = INDEX_NONE;
            r.scale     = 2'd0;
        end
        case ($urandom_range(0, 3))
            0:       r.displacement = '0;
            1:       r.displacement = 32'($urandom_range(0, 255) - 128);
            2:       r.displacement = 32'(boundary[$urandom_range(0, 3)]);
            default: r.displacement = $urandom;
        endcase
        return r;
    endfunction

    function automatic req_t memory_request(logic [4:0] mode, logic [3:0] reg_num,
                                            logic [3:0] base, logic [3:0] index,
                                            logic [1:0] scale, logic [31:0] disp);
        req_t r;
        r              = random_request();
        r.mode         = mode;
        r.dst_reg      = reg_num;
        r.src_reg      = reg_num;
        r.base_reg     = base;
        r.index_reg    = index;
        r.scale        = scale;
        r.displacement = disp;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        int      gap;
        code_q_t code;
        res_t    expected_byte;
        gap = tx_calm ? 0 : draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        code = encode_instruction(r);
        foreach (code[k])
        begin
            expected_byte.code_byte = code[k];
            expected_byte.last_byte = (k == code.size() - 1);
            code_expected.push_back(expected_byte);
        end
    endtask

    task automatic test_extreme_fields();
        req_t r;
        r           = '0;
        r.mode      = MODE_MOV_IMM64;
        r.dst_reg   = 4'hF;
        r.immediate = '1;
        send_request(r);
        r           = '1;
        r.mode      = MODE_MOV_IMM64;
        r.dst_reg   = 4'h0;
        r.immediate = '0;
        send_request(r);
    endtask

    task automatic test_every_form();
        req_t r;
        for (int m = 0; m <= int'(MODE_POP); m++)
        begin
            if (m != MODE_STORE && m != MODE_LOAD && m != MODE_LEA)
            begin
                r         = random_request();
                r.mode    = 5'(m);
                r.dst_reg = {m[0], 3'($urandom)};
                send_request(r);
            end
        end
    endtask

    task automatic test_memory_operands();
        send_request(memory_request(MODE_LOAD, 4'd1, {1'b0, RM_SIB}, INDEX_NONE, 2'd0, 32'd0));
        send_request(memory_request(MODE_STORE, 4'd9, {1'b0, RM_BP}, INDEX_NONE, 2'd0, 32'd0));
        send_request(memory_request(MODE_LEA, 4'd15, {1'b1, RM_BP}, 4'd9, 2'd3, 32'd127));
        send_request(memory_request(MODE_LOAD, 4'd0, {1'b1, RM_SIB}, INDEX_NONE, 2'd0, -32'sd128));
        send_request(memory_request(MODE_STORE, 4'd2, 4'd0, INDEX_NONE, 2'd2, 32'd128));
        send_request(memory_request(MODE_LEA, 4'd7, 4'd15, INDEX_NONE, 2'd0, -32'sd129));
        send_request(memory_request(MODE_LOAD, 4'd8, 4'd8, 4'd15, 2'd1, 32'h8000_0000));
        send_request(memory_request(MODE_STORE, 4'd15, 4'd7, 4'd0, 2'd0, 32'h7FFF_FFFF));
        send_request(memory_request(MODE_LEA, 4'd3, 4'd3, INDEX_NONE, 2'd0, 32'd0));
    endtask

    task automatic test_unused_forms();
        req_t r;
        r      = random_request();
        r.mode = 5'(2**5 - 1);
        send_request(r);
    endtask

    task automatic test_random_stream(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request());
        end
        rx_calm = 1'b0;
    endtask

    task automatic test_back_pressure(input int count);
        tx_calm = 1'b1;
        hold_ticket <= hold_ticket + 1;
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
        tx_calm = 1'b0;
    endtask

    task automatic test_no_idling(input int count);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_receiver
        if (hold_ticket != hold_taken)
        begin
            hold_taken = hold_ticket;
            hold_left  = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                stall_left = rx_calm ? 0 : draw_wait();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : byte_checker
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (code_expected.size() == 0)
            begin
                $error("code_byte: expected none, actual %h", res.code_byte);
                mismatches++;
            end
            else
            begin
                want = code_expected.pop_front();
                if (res.code_byte !== want.code_byte)
                begin
                    $error("code_byte: expected %h, actual %h", want.code_byte, res.code_byte);
                    mismatches++;
                end
                if (res.last_byte !== want.last_byte)
                begin
                    $error("last_byte: expected %b, actual %b", want.last_byte, res.last_byte);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_extreme_fields();
        test_every_form();
        test_memory_operands();
        test_unused_forms();
        test_random_stream(340);
        test_back_pressure(50);
        test_no_idling(50);
        req_valid <= 1'b0;
        while (code_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/xenc_pkg.sv
design/xenc_encode.sv
design/xenc_serial.sv
design/x86_64_instruction_byte_encoder_top.sv
tb/tb_top.sv
